// ===== sv/mea_pkg.sv =====
// Package for the monomial exponent ALU: widths, field offsets, operation and status codes,
// and the structs passed between the lane units, the reduction and the top level.
// No dependencies.
package mea_pkg;

	localparam int NUM_LANES = 8;
	localparam int EXP_WIDTH = 8;
	localparam int VEC_WIDTH = 64;
	localparam int ACT_WIDTH = 4;
	localparam int OP_WIDTH = 3;
	localparam int PWR_WIDTH = 16;
	localparam int STAT_WIDTH = 2;
	localparam int IDX_WIDTH = 3;
	localparam int DEG_WIDTH = 11;
	localparam int NUM_PAIRS = (NUM_LANES + 1) / 2;
	localparam int PAIR_WIDTH = EXP_WIDTH + 1;

	localparam logic [ACT_WIDTH-1:0] ACT_RESET = ACT_WIDTH'(NUM_LANES);

	// s_tdata layout
	localparam int OFS_OP = 0;
	localparam int OFS_A = OFS_OP + OP_WIDTH;
	localparam int OFS_B = OFS_A + VEC_WIDTH;
	localparam int OFS_PW = OFS_B + VEC_WIDTH;
	localparam int IN_BITS = OFS_PW + PWR_WIDTH;
	localparam int IN_DATA_WIDTH = ((IN_BITS + 7) / 8) * 8;

	// m_tdata layout
	localparam int OFS_STAT = VEC_WIDTH;
	localparam int OFS_DIV = OFS_STAT + STAT_WIDTH;
	localparam int OFS_COP = OFS_DIV + 1;
	localparam int OFS_ONE = OFS_COP + 1;
	localparam int OFS_SQF = OFS_ONE + 1;
	localparam int OFS_IND = OFS_SQF + 1;
	localparam int OFS_IDX = OFS_IND + 1;
	localparam int OFS_DEG = OFS_IDX + IDX_WIDTH;
	localparam int OUT_BITS = OFS_DEG + DEG_WIDTH;
	localparam int OUT_DATA_WIDTH = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [OP_WIDTH-1:0] OP_MUL = 3'd0;
	localparam logic [OP_WIDTH-1:0] OP_DIV = 3'd1;
	localparam logic [OP_WIDTH-1:0] OP_COLON = 3'd2;
	localparam logic [OP_WIDTH-1:0] OP_GCD = 3'd3;
	localparam logic [OP_WIDTH-1:0] OP_LCM = 3'd4;
	localparam logic [OP_WIDTH-1:0] OP_RAD = 3'd5;
	localparam logic [OP_WIDTH-1:0] OP_POW = 3'd6;

	localparam logic [STAT_WIDTH-1:0] ST_OK = 2'd0;
	localparam logic [STAT_WIDTH-1:0] ST_OVF = 2'd1;
	localparam logic [STAT_WIDTH-1:0] ST_UNF = 2'd2;

	typedef logic [EXP_WIDTH-1:0] lane_t;
	typedef logic [PAIR_WIDTH-1:0] pair_t;

	typedef struct packed {
		logic [OP_WIDTH-1:0] op;
		logic pw_big;
	} ctrl_t;

	typedef struct packed {
		lane_t r;
		logic ovf;
		logic unf;
		logic lt;
		logic nz;
		logic nzb;
		logic gt1;
		logic eq1;
	} lane_out_t;

	typedef struct packed {
		logic [VEC_WIDTH-1:0] result_vector;
		logic [STAT_WIDTH-1:0] status;
		logic b_divides_a;
		logic coprime;
		logic a_is_one;
		logic a_square_free;
		logic a_is_indet;
		logic [IDX_WIDTH-1:0] indet_index;
		logic [DEG_WIDTH-1:0] std_degree;
	} result_t;

endpackage

// ===== sv/monomial_exponent_alu_unit.sv =====
// Top level of the monomial exponent ALU: stream ports, lane-count register and
// the three-stage pipeline. Depends on mea_pkg, mea_lane and mea_reduce.
//
// Usage:
//   The slave stream (s_tvalid/s_tready/s_tdata) carries one operand pair per
//   transaction: operation, vector_a, vector_b and power. The master stream
//   (m_tvalid/m_tready/m_tdata) returns one result per transaction, in order.
//   cfg_we/cfg_wdata write active_indets (lanes at or above it read as zero);
//   write it only while no transaction is in flight.
//   On the way from acceptance to m_tvalid, stage 1 registers the
//   masked operands, stage 2 the per-lane results (one 8x8 multiply per lane
//   is the deepest path), stage 3 the reduced flags, degree and status.
//   Throughput is one transaction per cycle while m_tready is high.
//   Reset clears all valid bits and sets active_indets to 8.
//   When m_tready is low with a result waiting, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated, and flow resumes at full
//   rate once m_tready returns.
module monomial_exponent_alu_unit import mea_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ACT_WIDTH-1:0]      cfg_wdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// operation, vector_a, vector_b, power, zero fill
	input  logic [IN_DATA_WIDTH-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// result_vector, status, b_divides_a, coprime, a_is_one, a_square_free,
	// a_is_indet, indet_index, std_degree, zero fill
	output logic [OUT_DATA_WIDTH-1:0] m_tdata
);

	logic [ACT_WIDTH-1:0] active_q;
	logic                 adv;
	logic                 v_s1, v_s2, v_s3;

	ctrl_t                     ctrl_in, ctrl_s1, ctrl_s2;
	lane_t [NUM_LANES-1:0]     a_in, b_in, a_s1, b_s1;
	lane_t                     pw_s1;
	lane_out_t [NUM_LANES-1:0] lanes_c, lanes_s2;
	pair_t [NUM_PAIRS-1:0]     pairs_c, pairs_s2;
	result_t                   res_c, res_s3;
	logic [PWR_WIDTH-1:0]      pw_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			active_q <= ACT_RESET;
		else if (cfg_we)
			active_q <= cfg_wdata;
	end

	assign adv = !v_s3 || m_tready;
	assign s_tready = adv;

	// input decode and lane masking
	assign pw_in = s_tdata[OFS_PW +: PWR_WIDTH];
	assign ctrl_in.op = s_tdata[OFS_OP +: OP_WIDTH];
	assign ctrl_in.pw_big = (pw_in > PWR_WIDTH'((1 << EXP_WIDTH) - 1));

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			if (active_q > ACT_WIDTH'(i)) begin
				a_in[i] = s_tdata[OFS_A + i*EXP_WIDTH +: EXP_WIDTH];
				b_in[i] = s_tdata[OFS_B + i*EXP_WIDTH +: EXP_WIDTH];
			end else begin
				a_in[i] = '0;
				b_in[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s1 <= ctrl_in;
			a_s1 <= a_in;
			b_s1 <= b_in;
			pw_s1 <= pw_in[EXP_WIDTH-1:0];
			ctrl_s2 <= ctrl_s1;
			lanes_s2 <= lanes_c;
			pairs_s2 <= pairs_c;
			res_s3 <= res_c;
		end
	end

	// stage 2: lane operations and degree pair sums
	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		mea_lane u_lane (
			.ctrl (ctrl_s1),
			.a    (a_s1[i]),
			.b    (b_s1[i]),
			.pw   (pw_s1),
			.lane (lanes_c[i])
		);
	end

	for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pair
		if (2*p + 1 < NUM_LANES) begin : g_two
			assign pairs_c[p] = {1'b0, a_s1[2*p]} + {1'b0, a_s1[2*p+1]};
		end else begin : g_one
			assign pairs_c[p] = {1'b0, a_s1[2*p]};
		end
	end

	// stage 3: cross-lane reduction
	mea_reduce u_reduce (
		.ctrl  (ctrl_s2),
		.lanes (lanes_s2),
		.pairs (pairs_s2),
		.res   (res_c)
	);

	assign m_tvalid = v_s3;

	always_comb begin
		m_tdata = '0;
		m_tdata[0 +: VEC_WIDTH] = res_s3.result_vector;
		m_tdata[OFS_STAT +: STAT_WIDTH] = res_s3.status;
		m_tdata[OFS_DIV] = res_s3.b_divides_a;
		m_tdata[OFS_COP] = res_s3.coprime;
		m_tdata[OFS_ONE] = res_s3.a_is_one;
		m_tdata[OFS_SQF] = res_s3.a_square_free;
		m_tdata[OFS_IND] = res_s3.a_is_indet;
		m_tdata[OFS_IDX +: IDX_WIDTH] = res_s3.indet_index;
		m_tdata[OFS_DEG +: DEG_WIDTH] = res_s3.std_degree;
	end

	a_indet_sqfree: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && res_s3.a_is_indet |-> res_s3.a_square_free && !res_s3.a_is_one)
		else $error("single indeterminate flagged with non square-free or unit a");

	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !res_s3.a_is_indet |-> res_s3.indet_index == '0)
		else $error("indet_index nonzero without a single indeterminate");

	a_one_deg: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && res_s3.a_is_one |-> res_s3.std_degree == '0 && res_s3.coprime)
		else $error("unit a with nonzero degree or not coprime");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s2 |=> v_s3)
		else $error("valid item dropped between stage 2 and stage 3");

endmodule

// ===== sv/mea_lane.sv =====
// One exponent lane: applies the selected operation to a pair of exponents and
// derives the per-lane query bits. Combinational. Depends on mea_pkg.
module mea_lane import mea_pkg::*; (
	input  ctrl_t     ctrl,
	input  lane_t     a,
	input  lane_t     b,
	input  lane_t     pw,
	output lane_out_t lane
);

	logic [EXP_WIDTH:0]     sum;
	logic [2*EXP_WIDTH-1:0] prod;

	assign sum = {1'b0, a} + {1'b0, b};
	assign prod = a * pw;

	always_comb begin
		lane.r = '0;
		lane.ovf = 1'b0;
		lane.unf = 1'b0;
		case (ctrl.op)
			OP_MUL: begin
				lane.r = sum[EXP_WIDTH-1:0];
				lane.ovf = sum[EXP_WIDTH];
			end
			OP_DIV: begin
				lane.r = a - b;
				lane.unf = (a < b);
			end
			OP_COLON: begin
				lane.r = (a > b) ? a - b : '0;
			end
			OP_GCD: begin
				lane.r = (a < b) ? a : b;
			end
			OP_LCM: begin
				lane.r = (a > b) ? a : b;
			end
			OP_RAD: begin
				lane.r = EXP_WIDTH'(a != '0);
			end
			OP_POW: begin
				if (!ctrl.pw_big) begin
					lane.r = prod[EXP_WIDTH-1:0];
					lane.ovf = |prod[2*EXP_WIDTH-1:EXP_WIDTH];
				end
			end
			default: begin
				lane.r = '0;
			end
		endcase
		lane.lt = (a < b);
		lane.nz = (a != '0);
		lane.nzb = (b != '0);
		lane.gt1 = (a > EXP_WIDTH'(1));
		lane.eq1 = (a == EXP_WIDTH'(1));
	end

endmodule

// ===== sv/mea_reduce.sv =====
// Reduction across lanes: packs the result vector, resolves status, and forms
// the query flags, indeterminate index and degree. Depends on mea_pkg.
module mea_reduce import mea_pkg::*; (
	input  ctrl_t                       ctrl,
	input  lane_out_t [NUM_LANES-1:0]   lanes,
	input  pair_t     [NUM_PAIRS-1:0]   pairs,
	output result_t                     res
);

	logic [NUM_LANES-1:0] ovf, unf, lt, nz, nzb, gt1, eq1;
	logic [VEC_WIDTH-1:0] vec;
	logic [DEG_WIDTH-1:0] deg;
	logic [IDX_WIDTH-1:0] idx;
	logic                 single;

	always_comb begin
		vec = '0;
		idx = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			vec[i*EXP_WIDTH +: EXP_WIDTH] = lanes[i].r;
			ovf[i] = lanes[i].ovf;
			unf[i] = lanes[i].unf;
			lt[i] = lanes[i].lt;
			nz[i] = lanes[i].nz;
			nzb[i] = lanes[i].nzb;
			gt1[i] = lanes[i].gt1;
			eq1[i] = lanes[i].eq1;
			if (lanes[i].nz)
				idx = IDX_WIDTH'(i);
		end
		deg = '0;
		for (int p = 0; p < NUM_PAIRS; p++)
			deg = deg + DEG_WIDTH'(pairs[p]);
	end

	assign single = (nz != '0) && ((nz & (nz - 1'b1)) == '0) && ((nz & ~eq1) == '0);

	always_comb begin
		res.result_vector = (ctrl.op == OP_POW && ctrl.pw_big) ? '0 : vec;
		if (ctrl.op == OP_POW && ctrl.pw_big)
			res.status = ST_OVF;
		else if (|ovf)
			res.status = ST_OVF;
		else if (|unf)
			res.status = ST_UNF;
		else
			res.status = ST_OK;
		res.b_divides_a = ~|lt;
		res.coprime = ~|(nz & nzb);
		res.a_is_one = ~|nz;
		res.a_square_free = ~|gt1;
		res.a_is_indet = single;
		res.indet_index = single ? idx : '0;
		res.std_degree = deg;
	end

endmodule
